// ===== sv/detector_hit_merge_accumulator_assert.svh =====
// Assertion macros for the detector hit merge accumulator.
// Included by the top level; needs no other file.
`ifndef DETECTOR_HIT_MERGE_ACCUMULATOR_ASSERT_SVH
`define DETECTOR_HIT_MERGE_ACCUMULATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define DHMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DHMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DHMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DHMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/dhma_pkg.sv =====
// Shared types and constants of the detector hit merge accumulator.
// No dependencies.
package dhma_pkg;

    localparam int SECTORS_DEF   = 32;
    localparam int HIT_SLOTS_DEF = 64;

    localparam logic [35:0] MERGE_WINDOW_RST = 36'd16000;
    localparam logic [31:0] THRESHOLD_RST    = 32'd50000;
    localparam logic [6:0]  HIT_LIMIT_RST    = 7'd64;
    localparam logic [35:0] TIME_LIMIT_RST   = 36'd16000000000;

    typedef enum logic [1:0] {
        CFG_MERGE_WINDOW = 2'd0,
        CFG_THRESHOLD    = 2'd1,
        CFG_HIT_LIMIT    = 2'd2,
        CFG_TIME_LIMIT   = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_MERGED   = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_IGNORED  = 3'd3,
        ST_HIT      = 3'd4,
        ST_EMPTY    = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_WALK,
        S_READ,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [35:0] hit_time;
        logic [31:0] energy;
        logic [15:0] track;
        logic [7:0]  ptype;
    } t_entry;

    typedef struct packed {
        logic load;
        logic wr;
        logic start;
        logic step;
        logic merge;
        logic insert;
        logic rotate;
    } t_cell_ctl;

endpackage

// ===== sv/dhma_cell.sv =====
// One hit slot of every sector: slot memory, working entry and walk token.
// Depends on dhma_pkg.
module dhma_cell import dhma_pkg::*; #(
    parameter int SECTORS = SECTORS_DEF,
    localparam int SW = (SECTORS > 1) ? $clog2(SECTORS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cell_ctl     i_ctl,
    input  logic [SW-1:0] i_addr,
    input  logic          i_head,
    input  logic          i_prev_tok,
    input  t_entry        i_prev_ent,
    input  t_entry        i_next_ent,
    input  t_entry        i_new,
    input  logic [35:0]   i_mw,
    output t_entry        o_ent,
    output logic          o_tok,
    output logic          o_near,
    output logic          o_later
);

    t_entry      r_mem [SECTORS];
    t_entry      r_ent;
    logic        r_tok;
    logic        r_done;
    logic        w_later;
    logic [35:0] w_diff;
    logic [32:0] w_sum;

    assign w_later = r_ent.hit_time > i_new.hit_time;
    assign w_diff  = w_later ? (r_ent.hit_time - i_new.hit_time)
                             : (i_new.hit_time - r_ent.hit_time);
    assign w_sum   = {1'b0, r_ent.energy} + {1'b0, i_new.energy};

    assign o_ent   = r_ent;
    assign o_tok   = r_tok;
    assign o_near  = r_tok && (w_diff < i_mw);
    assign o_later = r_tok && w_later;

    // The token marks the slot under examination; done marks slots already passed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_ctl.start) begin
            r_tok  <= i_head;
            r_done <= 1'b0;
        end else if (i_ctl.step) begin
            r_tok  <= i_prev_tok;
            r_done <= r_done || r_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ent <= r_mem[i_addr];
        end else if (i_ctl.insert) begin
            if (r_tok) begin
                r_ent <= i_new;
            end else if (!r_done) begin
                r_ent <= i_prev_ent;
            end
        end else if (i_ctl.merge && r_tok) begin
            r_ent.energy <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
            if (w_later) begin
                r_ent.hit_time <= i_new.hit_time;
                r_ent.track    <= i_new.track;
                r_ent.ptype    <= i_new.ptype;
            end
        end else if (i_ctl.rotate) begin
            r_ent <= i_next_ent;
        end
        if (i_ctl.wr) begin
            r_mem[i_addr] <= r_ent;
        end
    end

endmodule

// ===== sv/detector_hit_merge_accumulator.sv =====
// Detector hit merge accumulator. A deposit request loads its sector's row of hits
// into a chain of HIT_SLOTS cells, walks a token along the chain one stored hit per
// cycle, then merges or inserts (shifting later hits one cell on) and writes the row
// back, or drops the hit when the row is at its hit limit. A read request rotates the
// row toward cell 0 one hit per cycle while the output side keeps up, and sends each
// hit above threshold. One request is worked on at a time; the output register lets
// the next request in while the last result waits.
module detector_hit_merge_accumulator import dhma_pkg::*; #(
    parameter int SECTORS   = SECTORS_DEF,
    parameter int HIT_SLOTS = HIT_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [4:0]  i_sector,
    input  logic [35:0] i_time_in,
    input  logic [35:0] i_time_out,
    input  logic [31:0] i_energy_deposit,
    input  logic [15:0] i_track_number,
    input  logic [7:0]  i_particle_type,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [4:0]  o_out_sector,
    output logic [35:0] o_hit_time,
    output logic [31:0] o_hit_energy,
    output logic [15:0] o_hit_track,
    output logic [7:0]  o_hit_type,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [35:0] i_cfg_data
);

`include "detector_hit_merge_accumulator_assert.svh"

    localparam int SW = (SECTORS > 1) ? $clog2(SECTORS) : 1;
    localparam int CW = $clog2(HIT_SLOTS + 1);

    t_state        r_state, n_state;
    logic [35:0]   r_merge_window, r_time_limit;
    logic [31:0]   r_threshold;
    logic [6:0]    r_hit_limit;

    logic          r_cmd, r_inrng;
    logic [4:0]    r_sec;
    logic [SW-1:0] r_addr;
    t_entry        r_new;
    logic [CW-1:0] r_cnt, r_idx, r_new_cnt;
    logic [CW-1:0] r_cmem [SECTORS];
    logic [SECTORS-1:0] r_cval;
    t_status       r_stat;
    logic          r_pv;
    t_entry        r_p;
    logic          r_wr_cells, r_wr_cnt;

    logic          r_ov;
    t_status       r_ostat;
    t_entry        r_oent;
    logic          r_olast;
    logic [4:0]    r_osec;

    t_entry        w_ent [HIT_SLOTS];
    logic [HIT_SLOTS-1:0] w_tok, w_near, w_later;
    t_cell_ctl     w_ctl;
    logic          w_accept, w_out_free, w_inrng, w_end, w_pass, w_any_near, w_any_later;
    logic          w_load_out, w_out_last;
    t_status       w_out_stat;
    t_entry        w_out_ent;
    logic [SW-1:0] w_addr;
    logic [36:0]   w_sum;
    logic [35:0]   w_t;
    logic [CW-1:0] w_lim;

    // Decisions taken in the walk and read states, applied in the data block.
    logic          w_do_merge, w_do_insert, w_do_drop, w_do_step, w_do_take;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_ov || i_out_ready;
    assign w_addr      = SW'(i_sector);
    assign w_inrng     = ({27'd0, i_sector} < 32'(SECTORS));
    assign w_sum       = {1'b0, i_time_in} + {1'b0, i_time_out};
    assign w_t         = (i_time_out > r_time_limit) ? i_time_in : w_sum[36:1];
    assign w_lim       = (r_hit_limit > 7'(HIT_SLOTS)) ? CW'(HIT_SLOTS) : CW'(r_hit_limit);
    assign w_end       = (r_idx == r_cnt);
    assign w_any_near  = |w_near;
    assign w_any_later = |w_later;
    assign w_pass      = w_ent[0].energy > r_threshold;

    genvar g;
    generate
        for (g = 0; g < HIT_SLOTS; g++) begin : g_cell
            dhma_cell #(.SECTORS(SECTORS)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_addr     (r_addr),
                .i_head     ((g == 0) ? 1'b1 : 1'b0),
                .i_prev_tok ((g == 0) ? 1'b0 : w_tok[(g == 0) ? 0 : g - 1]),
                .i_prev_ent ((g == 0) ? r_new : w_ent[(g == 0) ? 0 : g - 1]),
                .i_next_ent ((g == HIT_SLOTS - 1) ? w_ent[g]
                                                  : w_ent[(g == HIT_SLOTS - 1) ? g : g + 1]),
                .i_new      (r_new),
                .i_mw       (r_merge_window),
                .o_ent      (w_ent[g]),
                .o_tok      (w_tok[g]),
                .o_near     (w_near[g]),
                .o_later    (w_later[g])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        w_ctl       = '0;
        // The row is fetched once the request's sector address has been registered.
        w_ctl.load  = (r_state == S_DISP);
        w_load_out  = 1'b0;
        w_out_stat  = ST_HIT;
        w_out_ent   = r_p;
        w_out_last  = 1'b0;
        w_do_merge  = 1'b0;
        w_do_insert = 1'b0;
        w_do_drop   = 1'b0;
        w_do_step   = 1'b0;
        w_do_take   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_DISP;
            end
            S_DISP: begin
                if (!r_cmd && r_new.energy != 32'd0 && r_inrng) begin
                    w_ctl.start = 1'b1;
                    n_state     = S_WALK;
                end else if (r_cmd && r_inrng) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_WALK: begin
                if (!w_end && w_any_near) begin
                    w_do_merge  = 1'b1;
                    w_ctl.merge = 1'b1;
                    n_state     = S_FIN;
                end else if (w_end || w_any_later) begin
                    if (r_cnt >= w_lim) begin
                        w_do_drop = 1'b1;
                    end else begin
                        w_do_insert  = 1'b1;
                        w_ctl.insert = 1'b1;
                    end
                    n_state = S_FIN;
                end else begin
                    w_do_step  = 1'b1;
                    w_ctl.step = 1'b1;
                end
            end
            S_READ: begin
                if (w_end) begin
                    n_state = S_FIN;
                end else if (!(w_pass && r_pv && !w_out_free)) begin
                    w_ctl.rotate = 1'b1;
                    w_do_step    = 1'b1;
                    w_do_take    = w_pass;
                    w_load_out   = w_pass && r_pv;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    w_out_last = 1'b1;
                    w_out_stat = r_pv ? ST_HIT : r_stat;
                    w_out_ent  = r_pv ? r_p : '0;
                    w_ctl.wr   = r_wr_cells;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_window <= MERGE_WINDOW_RST;
            r_threshold    <= THRESHOLD_RST;
            r_hit_limit    <= HIT_LIMIT_RST;
            r_time_limit   <= TIME_LIMIT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == 8'(CFG_MERGE_WINDOW)) r_merge_window <= i_cfg_data;
            if (i_cfg_index == 8'(CFG_THRESHOLD))    r_threshold    <= i_cfg_data[31:0];
            if (i_cfg_index == 8'(CFG_HIT_LIMIT))    r_hit_limit    <= i_cfg_data[6:0];
            if (i_cfg_index == 8'(CFG_TIME_LIMIT))   r_time_limit   <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv       <= 1'b0;
            r_wr_cells <= 1'b0;
            r_wr_cnt   <= 1'b0;
            r_cval     <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (r_state == S_DISP) begin
                r_pv       <= 1'b0;
                r_wr_cells <= 1'b0;
                r_wr_cnt   <= r_cmd && r_inrng;
            end
            if (w_do_take) r_pv <= 1'b1;
            if (w_do_merge || w_do_insert) r_wr_cells <= 1'b1;
            if (w_do_insert) r_wr_cnt <= 1'b1;
            if (r_state == S_FIN && w_out_free) begin
                r_pv       <= 1'b0;
                r_wr_cells <= 1'b0;
                r_wr_cnt   <= 1'b0;
                if (r_wr_cnt) r_cval[r_addr] <= 1'b1;
            end
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd          <= i_command;
            r_sec          <= i_sector;
            r_addr         <= w_addr;
            r_inrng        <= w_inrng;
            r_new.hit_time <= w_t;
            r_new.energy   <= i_energy_deposit;
            r_new.track    <= i_track_number;
            r_new.ptype    <= i_particle_type;
            r_cnt          <= r_cval[w_addr] ? r_cmem[w_addr] : '0;
        end
        if (r_state == S_DISP) begin
            r_idx     <= '0;
            r_new_cnt <= '0;
            if (r_cmd) begin
                r_stat <= ST_EMPTY;
            end else if (r_new.energy == 32'd0) begin
                r_stat <= ST_IGNORED;
            end else begin
                r_stat <= ST_DROPPED;
            end
        end
        if (w_do_step) r_idx <= r_idx + 1'b1;
        if (w_do_take) r_p <= w_ent[0];
        if (w_do_merge) r_stat <= ST_MERGED;
        if (w_do_drop) r_stat <= ST_DROPPED;
        if (w_do_insert) begin
            r_stat    <= ST_INSERTED;
            r_new_cnt <= r_cnt + 1'b1;
        end
        if (r_state == S_FIN && w_out_free && r_wr_cnt) begin
            r_cmem[r_addr] <= r_new_cnt;
        end
        if (w_load_out) begin
            r_ostat <= w_out_stat;
            r_oent  <= w_out_ent;
            r_olast <= w_out_last;
            r_osec  <= r_sec;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_status     = r_ostat;
    assign o_out_sector = r_osec;
    assign o_hit_time   = r_oent.hit_time;
    assign o_hit_energy = r_oent.energy;
    assign o_hit_track  = r_oent.track;
    assign o_hit_type   = r_oent.ptype;
    assign o_last       = r_olast;

    `DHMA_ASSERT_NXT(a_accept_disp, i_clk, i_rst_n, w_accept, r_state == S_DISP)
    `DHMA_ASSERT_IMP(a_idx_in_count, i_clk, i_rst_n, r_state == S_WALK, r_idx <= r_cnt)
    `DHMA_ASSERT_IMP(a_one_token, i_clk, i_rst_n, 1'b1, $onehot0(w_tok))

endmodule

// ===== sim/tb_detector_hit_merge_accumulator.sv =====
// Self-checking testbench for detector_hit_merge_accumulator.
// Needs dhma_pkg and the block itself. A scoreboard predicts every result from the
// requests accepted, and plain tasks drive requests and register writes.
`timescale 1ns / 1ps

module tb_detector_hit_merge_accumulator import dhma_pkg::*;;

    localparam bit CMD_DEPOSIT = 1'b0;
    localparam bit CMD_READ    = 1'b1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = HIT_SLOTS_DEF + 16;

    typedef struct {
        bit          cmd;
        logic [4:0]  sector;
        logic [35:0] time_in;
        logic [35:0] time_out;
        logic [31:0] energy;
        logic [15:0] track;
        logic [7:0]  ptype;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [4:0]  sector;
        logic [35:0] hit_time;
        logic [31:0] energy;
        logic [15:0] track;
        logic [7:0]  ptype;
        logic        last;
    } t_result;

    class hit_scoreboard;
        t_entry      rows[SECTORS_DEF][HIT_SLOTS_DEF];
        int          counts[SECTORS_DEF];
        logic [35:0] merge_window;
        logic [31:0] threshold;
        logic [6:0]  hit_limit;
        logic [35:0] time_limit;
        t_result     pending[$];
        int          mismatches;

        function new();
            merge_window = MERGE_WINDOW_RST;
            threshold    = THRESHOLD_RST;
            hit_limit    = HIT_LIMIT_RST;
            time_limit   = TIME_LIMIT_RST;
            foreach (counts[s]) counts[s] = 0;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [35:0] value);
            case (idx)
                CFG_MERGE_WINDOW: merge_window = value;
                CFG_THRESHOLD:    threshold    = value[31:0];
                CFG_HIT_LIMIT:    hit_limit    = value[6:0];
                CFG_TIME_LIMIT:   time_limit   = value;
            endcase
        endfunction

        function void push(t_status st, logic [4:0] sec, t_entry e, logic last);
            t_result r;
            r.status = st; r.sector = sec; r.hit_time = e.hit_time;
            r.energy = e.energy; r.track = e.track; r.ptype = e.ptype; r.last = last;
            pending.push_back(r);
        endfunction

        function void note_request(t_request q);
            t_entry      none;
            t_entry      hit;
            logic [36:0] sum;
            logic [35:0] t;
            logic [35:0] h;
            logic [35:0] d;
            logic [32:0] esum;
            int          lim;
            int          i;
            int          n;
            int          sec;
            none = '0;
            sec = q.sector;
            if (q.cmd == CMD_READ) begin
                n = 0;
                for (i = 0; i < counts[sec]; i++) begin
                    if (rows[sec][i].energy > threshold) begin
                        push(ST_HIT, q.sector, rows[sec][i], 1'b0);
                        n++;
                    end
                end
                counts[sec] = 0;
                if (n == 0) push(ST_EMPTY, q.sector, none, 1'b1);
                else pending[$].last = 1'b1;
                return;
            end
            if (q.energy == 0) begin
                push(ST_IGNORED, q.sector, none, 1'b1);
                return;
            end
            sum = {1'b0, q.time_in} + {1'b0, q.time_out};
            t = (q.time_out > time_limit) ? q.time_in : sum[36:1];
            lim = (hit_limit > HIT_SLOTS_DEF) ? HIT_SLOTS_DEF : int'(hit_limit);
            for (i = 0; i < counts[sec]; i++) begin
                h = rows[sec][i].hit_time;
                d = (h > t) ? h - t : t - h;
                if (d < merge_window) begin
                    esum = {1'b0, rows[sec][i].energy} + {1'b0, q.energy};
                    rows[sec][i].energy = esum[32] ? 32'hFFFF_FFFF : esum[31:0];
                    // A later stored hit gives way to the earlier contribution.
                    if (h > t) begin
                        rows[sec][i].hit_time = t;
                        rows[sec][i].track = q.track;
                        rows[sec][i].ptype = q.ptype;
                    end
                    push(ST_MERGED, q.sector, none, 1'b1);
                    return;
                end
                if (h > t) break;
            end
            if (counts[sec] >= lim) begin
                push(ST_DROPPED, q.sector, none, 1'b1);
                return;
            end
            for (n = counts[sec]; n > i; n--) rows[sec][n] = rows[sec][n-1];
            hit.hit_time = t; hit.energy = q.energy; hit.track = q.track; hit.ptype = q.ptype;
            rows[sec][i] = hit;
            counts[sec]++;
            push(ST_INSERTED, q.sector, none, 1'b1);
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d sector %0d", got.status, got.sector);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected st %0d sec %0d t %0h e %0h trk %0h ty %0h",
                        want.status, want.sector, want.hit_time, want.energy, want.track,
                        want.ptype, " last %0b, got st %0d sec %0d t %0h e %0h trk %0h",
                        want.last, got.status, got.sector, got.hit_time, got.energy,
                        got.track, " ty %0h last %0b", got.ptype, got.last);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_command = 1'b0;
    logic [4:0]  i_sector = '0;
    logic [35:0] i_time_in = '0;
    logic [35:0] i_time_out = '0;
    logic [31:0] i_energy_deposit = '0;
    logic [15:0] i_track_number = '0;
    logic [7:0]  i_particle_type = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [4:0]  o_out_sector;
    logic [35:0] o_hit_time;
    logic [31:0] o_hit_energy;
    logic [15:0] o_hit_track;
    logic [7:0]  o_hit_type;
    logic        o_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [35:0] i_cfg_data = '0;

    hit_scoreboard sb;
    int            cycles = 0;
    logic [35:0]   sector_base[SECTORS_DEF];

    detector_hit_merge_accumulator dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idling is switched off for a long stretch in the middle of the run.
    function automatic bit take_break();
        if (cycles > 4000 && cycles < 12000) return 1'b0;
        return $urandom_range(0, 99) < 12;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** detector_hit_merge_accumulator: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_result r;
        i_out_ready <= i_rst_n && !take_break();
        if (i_rst_n && o_out_valid && i_out_ready) begin
            r.status = t_status'(o_status); r.sector = o_out_sector;
            r.hit_time = o_hit_time; r.energy = o_hit_energy; r.track = o_hit_track;
            r.ptype = o_hit_type; r.last = o_last;
            sb.check_result(r);
        end
    end

    function automatic logic [35:0] rand36();
        return 36'({$urandom, $urandom});
    endfunction

    // Valid stays high between back-to-back requests; it only drops for a gap.
    task automatic send_request(t_request q);
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= q.cmd; i_sector <= q.sector;
        i_time_in <= q.time_in; i_time_out <= q.time_out;
        i_energy_deposit <= q.energy; i_track_number <= q.track; i_particle_type <= q.ptype;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(q);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [35:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= 8'(idx);
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic configure(logic [35:0] window, logic [31:0] thr, logic [6:0] lim,
                             logic [35:0] tlim);
        write_reg(CFG_MERGE_WINDOW, window);
        write_reg(CFG_THRESHOLD, {4'd0, thr});
        write_reg(CFG_HIT_LIMIT, {29'd0, lim});
        write_reg(CFG_TIME_LIMIT, tlim);
        @(posedge i_clk);
    endtask

    function automatic t_request make_deposit(logic [4:0] sec, logic [35:0] tin,
                                              logic [35:0] tout, logic [31:0] e);
        t_request q;
        q.cmd = CMD_DEPOSIT; q.sector = sec; q.time_in = tin; q.time_out = tout;
        q.energy = e; q.track = 16'($urandom); q.ptype = 8'($urandom);
        return q;
    endfunction

    function automatic t_request make_read(logic [4:0] sec);
        t_request q;
        q = make_deposit(sec, rand36(), rand36(), $urandom);
        q.cmd = CMD_READ;
        return q;
    endfunction

    // Most deposits land in a few sectors, close in time, so that lists fill and merge.
    function automatic t_request random_request();
        t_request    q;
        logic [4:0]  sec;
        logic [35:0] tin;
        logic [31:0] e;
        int          pick;
        pick = $urandom_range(0, 99);
        sec = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
        if (pick < 9) return make_read(sec);
        if (pick < 12) return make_deposit(sec, rand36(), rand36(), $urandom);
        tin = sector_base[sec] + $urandom_range(0, 300000);
        case ($urandom_range(0, 9))
            0:       e = 32'd0;
            1:       e = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            2, 3:    e = $urandom;
            default: e = $urandom_range(1, 120000);
        endcase
        q = make_deposit(sec, tin, tin + $urandom_range(0, 4000), e);
        if ($urandom_range(0, 9) == 0) q.time_out = rand36();
        return q;
    endfunction

    initial begin
        logic [35:0] tmax;
        int          p;
        int          k;
        tmax = '1;
        sb = new();
        foreach (sector_base[s]) sector_base[s] = rand36() >> $urandom_range(0, 12);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset settings.
        send_request(make_read(5'd7));
        send_request(make_deposit(5'd1, 36'd1000, 36'd3000, 32'd0));
        send_request(make_deposit(5'd1, 36'd100000, 36'd100002, 32'd60000));
        send_request(make_deposit(5'd1, 36'd90000, 36'd90000, 32'd70000));
        send_request(make_deposit(5'd1, 36'd110000, 36'd110001, 32'hFFFF_FFFF));
        send_request(make_deposit(5'd1, 36'd300000, 36'd300000, 32'd10));
        send_request(make_deposit(5'd1, 36'd200000, 36'd200000, 32'd80000));
        send_request(make_deposit(5'd1, 36'd120000, tmax, 32'hFFFF_FFFF));
        send_request(make_deposit(5'd31, tmax, tmax, 32'd99999));
        send_request(make_deposit(5'd31, tmax - 1, tmax, 32'd1));
        send_request(make_deposit(5'd31, 36'd0, 36'd0, 32'd50001));
        send_request(make_deposit(5'd31, 36'd5, tmax, 32'd50000));
        send_request(make_read(5'd1));
        send_request(make_read(5'd31));
        send_request(make_read(5'd1));
        settle();

        // Single slot, no merging, everything read out, time_in never chosen.
        configure(36'd0, 32'd0, 7'd1, tmax);
        send_request(make_deposit(5'd2, 36'd500, 36'd500, 32'd1));
        send_request(make_deposit(5'd2, 36'd500, 36'd500, 32'd2));
        send_request(make_deposit(5'd2, 36'd10, tmax, 32'd3));
        send_request(make_read(5'd2));
        send_request(make_read(5'd2));
        settle();

        // Zero limit stores nothing; every out time selects the in time.
        configure(tmax, 32'hFFFF_FFFF, 7'd0, 36'd0);
        send_request(make_deposit(5'd3, 36'd7, 36'd9, 32'd4));
        send_request(make_read(5'd3));
        settle();

        for (p = 0; p < 5; p++) begin
            case (p)
                0: configure(36'd16000, 32'd50000, 7'd127, 36'd16000000000);
                1: configure(36'd40000, 32'd20000, 7'd4, 36'($urandom_range(0, 400000)));
                2: configure(36'd0, 32'd0, 7'd64, tmax);
                3: configure(tmax, 32'hFFFF_FFFF, 7'd0, rand36());
                default: configure(36'($urandom_range(0, 60000)), $urandom_range(0, 150000),
                                   7'($urandom_range(0, 127)), rand36());
            endcase
            for (k = 0; k < 50; k++) send_request(random_request());
            settle();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("** detector_hit_merge_accumulator: PASSED **");
        else
            $display("** detector_hit_merge_accumulator: FAILED **");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/dhma_pkg.sv
sv/dhma_cell.sv
sv/detector_hit_merge_accumulator.sv
sim/tb_detector_hit_merge_accumulator.sv
